[hdl/ffx_pkg.sv]
// Shared types and constants of the form field extractor.
package ffx_pkg;

  // Longest key and largest raw value length.
  localparam int KEY_MAX   = 16;
  localparam int VALUE_MAX = 1023;

  // Depth of the queue between the decoder and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_FIRST = 2'd0;
  localparam logic [1:0] REG_KEY_LAST  = 2'd1;
  localparam logic [1:0] REG_KEY_LEN   = 2'd2;
  localparam logic [1:0] REG_VAL_LIMIT = 2'd3;

  // Result kinds.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration as seen by the decoder.
  typedef struct packed {
    logic [63:0] key_first_bytes;
    logic [63:0] key_last_bytes;
    logic [4:0]  key_length;
    logic [9:0]  value_limit;
  } cfg_t;

  // All results caused by one input item: up to three value bytes, then
  // an optional end report.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            report;
    logic            found;
  } entry_t;

endpackage

[hdl/ffx_front.sv]
// Front end: key search, value truncation and percent decoding of body bytes.
module ffx_front (
  input  logic          clk,
  input  logic          rst,
  input  ffx_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    body_byte,
  input  logic          body_last,
  output logic          push,
  output ffx_pkg::entry_t entry
);
  import ffx_pkg::*;

  // Search phases.
  localparam logic [1:0] PH_COMPARE = 2'd0;
  localparam logic [1:0] PH_SKIP    = 2'd1;
  localparam logic [1:0] PH_VALUE   = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // Escape phases.
  localparam logic [1:0] ESC_NONE    = 2'd0;
  localparam logic [1:0] ESC_PERCENT = 2'd1;
  localparam logic [1:0] ESC_DIGIT   = 2'd2;

  // Characters.
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    hex_val = d[3:0];
  endfunction

  // Per-body state.
  logic [1:0] search_phase, search_phase_next;
  logic [4:0] key_position, key_position_next;
  logic [9:0] raw_value_count, raw_value_count_next;
  logic [1:0] escape_phase, escape_phase_next;
  logic [7:0] held_hex_digit, held_hex_digit_next;
  logic       match_found, match_found_next;
  logic       output_ended, output_ended_next;
  logic       body_ended, body_ended_next;

  logic [4:0]   klen;
  logic [9:0]   limit;
  logic [127:0] key_all;
  logic [7:0]   key_char;
  logic         fin;
  logic [7:0]   cand [3];
  logic [1:0]   cand_cnt;
  logic [1:0]   nb;
  logic         ended;
  logic         found_val;

  // Effective key length and value limit.
  always_comb begin
    if (cfg.key_length == 5'd0) begin
      klen = 5'd1;
    end else if (cfg.key_length > 5'(KEY_MAX)) begin
      klen = 5'(KEY_MAX);
    end else begin
      klen = cfg.key_length;
    end
    if ({1'b0, cfg.value_limit} > 11'(VALUE_MAX)) begin
      limit = 10'(VALUE_MAX);
    end else begin
      limit = cfg.value_limit;
    end
  end

  assign key_all  = {cfg.key_last_bytes, cfg.key_first_bytes};
  assign key_char = key_all[key_position[3:0] * 8 +: 8];

  // One step of the search and decode for the offered byte.
  always_comb begin
    search_phase_next    = search_phase;
    key_position_next    = key_position;
    raw_value_count_next = raw_value_count;
    escape_phase_next    = escape_phase;
    held_hex_digit_next  = held_hex_digit;
    match_found_next     = match_found;
    body_ended_next      = body_ended;
    fin                  = 1'b0;
    cand_cnt             = 2'd0;
    cand[0]              = 8'h00;
    cand[1]              = 8'h00;
    cand[2]              = 8'h00;

    if (!body_ended) begin
      if (body_byte == 8'h00) begin
        body_ended_next = 1'b1;
        if (search_phase == PH_VALUE) begin
          fin = 1'b1;
        end
      end else begin
        case (search_phase)
          PH_COMPARE: begin
            if (key_position < klen) begin
              if (body_byte == key_char) begin
                key_position_next = key_position + 5'd1;
              end else if (body_byte == CH_AMP) begin
                key_position_next = 5'd0;
              end else begin
                search_phase_next = PH_SKIP;
              end
            end else if (body_byte == CH_EQ) begin
              match_found_next     = 1'b1;
              search_phase_next    = PH_VALUE;
              raw_value_count_next = 10'd0;
              if (limit == 10'd0) begin
                fin = 1'b1;
              end
            end else if (body_byte == CH_AMP) begin
              key_position_next = 5'd0;
            end else begin
              search_phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (body_byte == CH_AMP) begin
              search_phase_next = PH_COMPARE;
              key_position_next = 5'd0;
            end
          end
          PH_VALUE: begin
            if (body_byte == CH_AMP || raw_value_count >= limit) begin
              fin = 1'b1;
            end else begin
              // Percent decoding of one raw value byte.
              if (escape_phase == ESC_PERCENT && hex_ok(body_byte)) begin
                held_hex_digit_next = body_byte;
                escape_phase_next   = ESC_DIGIT;
              end else if (escape_phase == ESC_DIGIT && hex_ok(body_byte)) begin
                cand[cand_cnt]      = {hex_val(held_hex_digit), hex_val(body_byte)};
                cand_cnt            = cand_cnt + 2'd1;
                escape_phase_next   = ESC_NONE;
                held_hex_digit_next = 8'h00;
              end else begin
                // A broken escape is flushed literally, then the byte decodes afresh.
                if (escape_phase != ESC_NONE) begin
                  cand[cand_cnt] = CH_PERCENT;
                  cand_cnt       = cand_cnt + 2'd1;
                end
                if (escape_phase == ESC_DIGIT) begin
                  cand[cand_cnt] = held_hex_digit;
                  cand_cnt       = cand_cnt + 2'd1;
                end
                escape_phase_next   = ESC_NONE;
                held_hex_digit_next = 8'h00;
                if (body_byte == CH_PERCENT) begin
                  escape_phase_next = ESC_PERCENT;
                end else if (body_byte == CH_PLUS) begin
                  cand[cand_cnt] = CH_SPACE;
                  cand_cnt       = cand_cnt + 2'd1;
                end else begin
                  cand[cand_cnt] = body_byte;
                  cand_cnt       = cand_cnt + 2'd1;
                end
              end
              raw_value_count_next = raw_value_count + 10'd1;
              if (raw_value_count_next >= limit) begin
                fin = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (body_last && search_phase_next == PH_VALUE) begin
      fin = 1'b1;
    end

    // End of value: flush any pending escape literally.
    if (fin) begin
      if (escape_phase_next != ESC_NONE) begin
        cand[cand_cnt] = CH_PERCENT;
        cand_cnt       = cand_cnt + 2'd1;
      end
      if (escape_phase_next == ESC_DIGIT) begin
        cand[cand_cnt] = held_hex_digit_next;
        cand_cnt       = cand_cnt + 2'd1;
      end
      escape_phase_next   = ESC_NONE;
      held_hex_digit_next = 8'h00;
      search_phase_next   = PH_DONE;
    end

    // Output stops after a decoded zero byte; the kept bytes form a prefix.
    ended = output_ended;
    nb    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cand_cnt && !ended) begin
        nb = nb + 2'd1;
        if (cand[i] == 8'h00) begin
          ended = 1'b1;
        end
      end
    end
    output_ended_next = ended;
    found_val         = match_found_next;

    // The report closes the body and clears its state.
    if (body_last) begin
      search_phase_next    = PH_COMPARE;
      key_position_next    = 5'd0;
      raw_value_count_next = 10'd0;
      escape_phase_next    = ESC_NONE;
      held_hex_digit_next  = 8'h00;
      match_found_next     = 1'b0;
      output_ended_next    = 1'b0;
      body_ended_next      = 1'b0;
    end
  end

  // Results of this item go to the queue when there are any.
  assign push         = accept && (nb != 2'd0 || body_last);
  assign entry.bytes  = {cand[2], cand[1], cand[0]};
  assign entry.nbytes = nb;
  assign entry.report = body_last;
  assign entry.found  = found_val;

  // State registers advance on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_phase    <= PH_COMPARE;
      key_position    <= 5'd0;
      raw_value_count <= 10'd0;
      escape_phase    <= ESC_NONE;
      held_hex_digit  <= 8'h00;
      match_found     <= 1'b0;
      output_ended    <= 1'b0;
      body_ended      <= 1'b0;
    end else if (accept) begin
      search_phase    <= search_phase_next;
      key_position    <= key_position_next;
      raw_value_count <= raw_value_count_next;
      escape_phase    <= escape_phase_next;
      held_hex_digit  <= held_hex_digit_next;
      match_found     <= match_found_next;
      output_ended    <= output_ended_next;
      body_ended      <= body_ended_next;
    end
  end

endmodule

[hdl/ffx_queue.sv]
// Small queue of result groups between the decoder and the output stage.
module ffx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ffx_pkg::entry_t push_entry,
  input  logic            pop,
  output ffx_pkg::entry_t head,
  output logic            full,
  output logic            empty
);
  import ffx_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/ffx_back.sv]
// Back end: unpacks queued result groups into single result items.
module ffx_back (
  input  logic            clk,
  input  logic            rst,
  input  ffx_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_value,
  output logic            out_found,
  output logic            out_kind,
  output logic            out_last
);
  import ffx_pkg::*;

  logic [1:0] pos;
  logic [2:0] last_pos;
  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;

  assign load     = !out_valid || out_ready;
  assign last_pos = {1'b0, head.nbytes} + {2'b00, head.report} - 3'd1;
  assign at_end   = ({1'b0, pos} == last_pos);
  assign pop      = load && !empty && at_end;

  // Byte at the current position of the head group.
  always_comb begin
    case (pos)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      2'd2:    sel_byte = head.bytes[2];
      default: sel_byte = 8'h00;
    endcase
  end

  // Output register with position counter inside the head group.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 2'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        pos <= at_end ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (pos < head.nbytes) begin
        out_value <= sel_byte;
        out_found <= 1'b0;
        out_kind  <= KIND_BYTE;
        out_last  <= 1'b0;
      end else begin
        out_value <= 8'h00;
        out_found <= head.found;
        out_kind  <= KIND_REPORT;
        out_last  <= 1'b1;
      end
    end
  end

endmodule

[hdl/form_field_extract_decode_core.sv]
// Top level of the form field extractor with percent decoding.
// The block scans a URL-encoded form body, one byte per item, for the first
// field named by the configured key and streams that field's value, cut to
// value_limit raw bytes and percent-decoded, as result items of kind 0; the
// final body byte (tlast) adds a report item of kind 1 that says whether the
// key was found. A body item is taken every cycle while the four-entry result
// queue has room; an item with n results (n is at most four, when an escape
// is flushed on the final byte) holds the output for all n; with output ready,
// only runs of such items stall input; results pass queue and output register.
// The user writes configuration only while the block is idle; it is unchecked.
module form_field_extract_decode_core (
  input  logic        clk,
  input  logic        rst,
  // Body input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  logic        s_axis_tlast,   // body_last
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [8] found, [15:9] zero
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // last
  // Configuration write port.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ffx_pkg::*;

  cfg_t       cfg;
  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  entry_t     push_entry;
  entry_t     head;
  logic [7:0] out_value;
  logic       out_found;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_first_bytes <= 64'd0;
      cfg.key_last_bytes  <= 64'd0;
      cfg.key_length      <= 5'd1;
      cfg.value_limit     <= 10'd7;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_FIRST: cfg.key_first_bytes <= cfg_data;
        REG_KEY_LAST:  cfg.key_last_bytes  <= cfg_data;
        REG_KEY_LEN:   cfg.key_length      <= cfg_data[4:0];
        REG_VAL_LIMIT: cfg.value_limit     <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Search and decode.
  ffx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .body_byte (s_axis_tdata),
    .body_last (s_axis_tlast),
    .push      (push),
    .entry     (push_entry)
  );

  // Result group queue.
  ffx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // Result serializer and output register.
  ffx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_found (out_found),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_found, out_value};

endmodule
